// ===== design/i2cm_pkg.sv =====
// shared types, constants and helpers of the i2c master byte engine
`default_nettype none

package i2cm_pkg;

  localparam int unsigned PHASE_CNT_BITS_DEF = 16;
  localparam int unsigned CFG_W              = 16;
  localparam logic [CFG_W-1:0] PHASE_TICKS_RST = 16'd200;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  localparam logic [4:0] START_PHASES = 5'd4;
  localparam logic [4:0] STOP_PHASES  = 5'd3;
  localparam logic [4:0] WRITE_PHASES = 5'd27;
  localparam logic [4:0] READ_PHASES  = 5'd19;

  // write command: phase of the ack bit, sampled at its end
  localparam logic [4:0] WR_ACK_SDA   = 5'd24;
  localparam logic [4:0] WR_ACK_SCL   = 5'd25;
  // read command: phase that drives the ack choice
  localparam logic [4:0] RD_ACK_SDA   = 5'd16;
  localparam logic [4:0] RD_ACK_SCL   = 5'd17;

  function automatic logic [4:0] phase_total(action_e act);
    logic [4:0] tot;
    case (act)
      ACT_START: tot = START_PHASES;
      ACT_STOP:  tot = STOP_PHASES;
      ACT_WRITE: tot = WRITE_PHASES;
      ACT_READ:  tot = READ_PHASES;
      default:   tot = READ_PHASES;
    endcase
    return tot;
  endfunction

endpackage

`default_nettype wire

// ===== design/i2cm_cmd_if.sv =====
// command channel: one bus tick with optional command and sampled sda
`default_nettype none

interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] action;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (
    output valid, cmd_valid, action, tx_byte, send_ack, sda_in,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, action, tx_byte, send_ack, sda_in,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/i2cm_res_if.sv =====
// result channel: line drives and status after one bus tick
`default_nettype none

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack;

  modport source (
    output valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte, nack,
    input  ready
  );
  modport sink (
    input  valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte, nack,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/i2cm_in_reg.sv =====
// input register stage of the command channel
`default_nettype none

module i2cm_in_reg (
  input  wire          clk_i,
  input  wire          rst_ni,
  i2cm_cmd_if.sink     up_i,
  i2cm_cmd_if.source   dn_o
);

  logic       vld_q;
  logic       cmd_valid_q;
  logic [1:0] action_q;
  logic [7:0] tx_byte_q;
  logic       send_ack_q;
  logic       sda_in_q;
  logic       up_fire;

  assign up_i.ready = !vld_q || dn_o.ready;
  assign up_fire    = up_i.valid && up_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (up_fire) begin
      vld_q <= 1'b1;
    end else if (dn_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_fire) begin
      cmd_valid_q <= up_i.cmd_valid;
      action_q    <= up_i.action;
      tx_byte_q   <= up_i.tx_byte;
      send_ack_q  <= up_i.send_ack;
      sda_in_q    <= up_i.sda_in;
    end
  end

  assign dn_o.valid     = vld_q;
  assign dn_o.cmd_valid = cmd_valid_q;
  assign dn_o.action    = action_q;
  assign dn_o.tx_byte   = tx_byte_q;
  assign dn_o.send_ack  = send_ack_q;
  assign dn_o.sda_in    = sda_in_q;

endmodule

`default_nettype wire

// ===== design/i2cm_core.sv =====
// bus phase sequencer: state update per tick and result register
`default_nettype none

module i2cm_core #(
  parameter int unsigned PHASE_COUNTER_BITS = i2cm_pkg::PHASE_CNT_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [i2cm_pkg::CFG_W-1:0]    cfg_wdata_i,
  i2cm_cmd_if.sink                     cmd_i,
  i2cm_res_if.source                   res_o
);

  localparam int unsigned CW = (PHASE_COUNTER_BITS + 1 > i2cm_pkg::CFG_W + 1) ?
                               PHASE_COUNTER_BITS + 1 : i2cm_pkg::CFG_W + 1;

  logic [i2cm_pkg::CFG_W-1:0]    phase_ticks_q;
  logic [4:0]                    phase_q, phase_d;
  logic [PHASE_COUNTER_BITS-1:0] tick_q, tick_d;
  i2cm_pkg::action_e             act_q, act_d;
  logic [7:0]                    shift_q, shift_d;
  logic                          ack_q, ack_d;
  logic                          busy_q, busy_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic [7:0]                    rx_q, rx_d;
  logic                          nack_q, nack_d;
  logic                          done_q, done_d;
  logic                          res_vld_q;

  logic                          in_fire;
  logic [CW-1:0]                 len_raw, len_cap, len, next_cnt;

  assign cmd_i.ready = !res_vld_q || res_o.ready;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  // effective phase length: zero acts as one, capped at the counter range
  assign len_raw  = (phase_ticks_q == '0) ? CW'(1) : CW'(phase_ticks_q);
  assign len_cap  = CW'(1) << PHASE_COUNTER_BITS;
  assign len      = (len_raw > len_cap) ? len_cap : len_raw;
  assign next_cnt = CW'(tick_q) + CW'(1);

  always_comb begin
    logic       enter_en;
    logic [8:0] prod;
    logic [2:0] bit_sel;
    logic [4:0] rem;
    phase_d  = phase_q;
    tick_d   = tick_q;
    act_d    = act_q;
    shift_d  = shift_q;
    ack_d    = ack_q;
    busy_d   = busy_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    nack_d   = nack_q;
    done_d   = 1'b0;
    enter_en = 1'b0;

    if (in_fire) begin
      if (busy_q) begin
        if (next_cnt >= len) begin
          // sample sda at the end of a released-scl phase
          if (act_q == i2cm_pkg::ACT_WRITE && phase_q == i2cm_pkg::WR_ACK_SCL) begin
            nack_d = cmd_i.sda_in;
          end else if (act_q == i2cm_pkg::ACT_READ && !phase_q[4] && !phase_q[0]) begin
            shift_d[~phase_q[3:1]] = shift_q[~phase_q[3:1]] | cmd_i.sda_in;
          end
          tick_d = '0;
          if (phase_q + 5'd1 >= i2cm_pkg::phase_total(act_q)) begin
            if (act_q == i2cm_pkg::ACT_READ) begin
              sda_d = 1'b0;
              rx_d  = shift_d;
            end
            busy_d  = 1'b0;
            phase_d = '0;
            done_d  = 1'b1;
          end else begin
            phase_d  = phase_q + 5'd1;
            enter_en = 1'b1;
          end
        end else begin
          tick_d = next_cnt[PHASE_COUNTER_BITS-1:0];
        end
      end else if (cmd_i.cmd_valid) begin
        act_d    = i2cm_pkg::action_e'(cmd_i.action);
        ack_d    = cmd_i.send_ack;
        shift_d  = (act_d == i2cm_pkg::ACT_WRITE) ? cmd_i.tx_byte : 8'd0;
        busy_d   = 1'b1;
        phase_d  = '0;
        tick_d   = '0;
        if (act_d == i2cm_pkg::ACT_READ) begin
          sda_d = 1'b0;
        end
        enter_en = 1'b1;
      end
    end

    // write phase split into bit and step within bit: p/3 as (p*11)>>5
    prod    = 9'(phase_d) * 9'd11;
    bit_sel = prod[7:5];
    rem     = phase_d - 5'(bit_sel) * 5'd3;

    if (enter_en) begin
      case (act_d)
        i2cm_pkg::ACT_START: begin
          case (phase_d[1:0])
            2'd0:    sda_d = 1'b0;
            2'd1:    scl_d = 1'b0;
            2'd2:    sda_d = 1'b1;
            default: scl_d = 1'b1;
          endcase
        end
        i2cm_pkg::ACT_STOP: begin
          case (phase_d[1:0])
            2'd0:    sda_d = 1'b1;
            2'd1:    scl_d = 1'b0;
            default: sda_d = 1'b0;
          endcase
        end
        i2cm_pkg::ACT_WRITE: begin
          if (phase_d < i2cm_pkg::WR_ACK_SDA) begin
            case (rem[1:0])
              2'd0:    sda_d = ~shift_d[~bit_sel];
              2'd1:    scl_d = 1'b0;
              default: scl_d = 1'b1;
            endcase
          end else if (phase_d == i2cm_pkg::WR_ACK_SDA) begin
            sda_d = 1'b0;
          end else if (phase_d == i2cm_pkg::WR_ACK_SCL) begin
            scl_d = 1'b0;
          end else begin
            scl_d = 1'b1;
          end
        end
        default: begin
          if (phase_d < i2cm_pkg::RD_ACK_SDA) begin
            scl_d = phase_d[0];
          end else if (phase_d == i2cm_pkg::RD_ACK_SDA) begin
            sda_d = ack_d;
          end else if (phase_d == i2cm_pkg::RD_ACK_SCL) begin
            scl_d = 1'b0;
          end else begin
            scl_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RST;
      phase_q       <= '0;
      tick_q        <= '0;
      act_q         <= i2cm_pkg::ACT_START;
      shift_q       <= '0;
      ack_q         <= 1'b0;
      busy_q        <= 1'b0;
      scl_q         <= 1'b0;
      sda_q         <= 1'b0;
      rx_q          <= '0;
      nack_q        <= 1'b0;
      done_q        <= 1'b0;
      res_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        act_q     <= act_d;
        shift_q   <= shift_d;
        ack_q     <= ack_d;
        busy_q    <= busy_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
        rx_q      <= rx_d;
        nack_q    <= nack_d;
        done_q    <= done_d;
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // the state only moves on a transaction, so it is the result itself
  assign res_o.valid         = res_vld_q;
  assign res_o.scl_drive_low = scl_q;
  assign res_o.sda_drive_low = sda_q;
  assign res_o.busy_res      = busy_q;
  assign res_o.done_res      = done_q;
  assign res_o.rx_byte       = rx_q;
  assign res_o.nack          = nack_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done reported while still busy");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (phase_q < i2cm_pkg::phase_total(act_q)))
    else $error("phase index past end of sequence");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (phase_q == '0 && tick_q == '0))
    else $error("idle with phase or tick count left over");

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !cfg_we_i && $stable(phase_ticks_q)) |-> (CW'(tick_q) < len))
    else $error("tick count reached phase length");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && busy_q && !busy_d) |=> done_q)
    else $error("end of sequence without done");

endmodule

`default_nettype wire

// ===== design/i2c_master_byte_engine.sv =====
// i2c master byte engine top level
//
// Usage: every transaction on cmd_i is one bus tick. It may carry a command
// (start, stop, write byte, read byte) with its byte and ack choice, and
// always carries the sda level sampled this tick. Each transaction yields
// exactly one transaction on res_o with the scl/sda pull-low drives, busy,
// a one-tick done pulse, the last received byte and the last write's nack.
// Commands offered while busy are dropped. Each bus phase lasts
// phase_ticks ticks (cfg_we_i / cfg_wdata_i, reset 200, zero acts as one);
// write it only while the engine is idle.
// A result is registered twice on its way: in the input register, then by
// the sequencer update into the result register.
// Throughput: one transaction per cycle while res_o takes results, set by
// the sequencer update. If res_o stalls, the result register holds and
// cmd_i backs up after one more transaction fills the input register;
// nothing is lost. Reset: both lines released, idle, counters and bytes
// cleared, phase length back to 200.
`default_nettype none

module i2c_master_byte_engine #(
  parameter int unsigned PHASE_COUNTER_BITS = i2cm_pkg::PHASE_CNT_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [i2cm_pkg::CFG_W-1:0]    cfg_wdata_i,
  i2cm_cmd_if.sink                     cmd_i,
  i2cm_res_if.source                   res_o
);

  i2cm_cmd_if cmd_reg_if ();

  i2cm_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .up_i   (cmd_i),
    .dn_o   (cmd_reg_if.source)
  );

  i2cm_core #(
    .PHASE_COUNTER_BITS (PHASE_COUNTER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_reg_if.sink),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
